// File: rtl/core/tmrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrd_pkg: shared definitions for the ternary multi-term row dot block
// Widths, reset values and register indexes used by the channels, the term
// scaling unit and the top level.
// ----------------------------------------------------------------------------
package tmrd_pkg;

  // Defaults for the top-level parameters.
  localparam int TERMS_DEF     = 8;
  localparam int ACT_WIDTH_DEF = 16;
  localparam int ACC_WIDTH_DEF = 40;

  // Fixed field widths.
  localparam int MASK_WIDTH     = 8;
  localparam int EXP_WIDTH      = 8;
  localparam int COUNT_WIDTH    = 4;
  localparam int TERM_WIDTH     = 60;
  localparam int OUT_WIDTH      = 48;
  localparam int CFG_IDX_WIDTH  = 4;
  localparam int CFG_DATA_WIDTH = 64;

  // Register reset values.
  localparam logic [COUNT_WIDTH-1:0]    ACTIVE_TERMS_RESET = COUNT_WIDTH'(4);
  localparam logic [CFG_DATA_WIDTH-1:0] EXPONENTS_RESET    = '0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ACTIVE_TERMS = CFG_IDX_WIDTH'(0),
    REG_EXPONENTS    = CFG_IDX_WIDTH'(1)
  } cfg_reg_t;

endpackage

// File: rtl/core/tmrd_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrd_channels: valid/ready channels of the row dot block
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// One activation with its per-term weight bits.
interface tmrd_in_if
  import tmrd_pkg::*;
#(
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [ACT_WIDTH-1:0] activation;
  logic [MASK_WIDTH-1:0]       nonzero_bits;
  logic [MASK_WIDTH-1:0]       negative_bits;
  logic                        row_last;

  modport source (output valid, activation, nonzero_bits, negative_bits, row_last,
                  input ready);
  modport sink (input valid, activation, nonzero_bits, negative_bits, row_last,
                output ready);
endinterface

// One finished row result.
interface tmrd_out_if
  import tmrd_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] row_sum;
  logic                        saturated;

  modport source (output valid, row_sum, saturated, input ready);
  modport sink (input valid, row_sum, saturated, output ready);
endinterface

// Register write channel.
interface tmrd_cfg_if
  import tmrd_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CFG_IDX_WIDTH-1:0]  index;
  logic [CFG_DATA_WIDTH-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/tmrd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmrd_scale: power-of-two scaling of one term accumulator
// Shifts a signed accumulator left or arithmetically right by a signed
// exponent and saturates the result to the signed term range.
// ----------------------------------------------------------------------------
module tmrd_scale
  import tmrd_pkg::*;
#(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic signed [ACC_WIDTH-1:0]  acc_value,
  input  logic signed [EXP_WIDTH-1:0]  exponent,
  output logic signed [TERM_WIDTH-1:0] term,
  output logic                         clip
);

  localparam int SH_WIDTH = $clog2(TERM_WIDTH);
  localparam logic signed [TERM_WIDTH-1:0] TERM_MAX = {1'b0, {(TERM_WIDTH-1){1'b1}}};
  localparam logic signed [TERM_WIDTH-1:0] TERM_MIN = {1'b1, {(TERM_WIDTH-1){1'b0}}};

  logic signed [TERM_WIDTH-1:0] ext;
  logic signed [TERM_WIDTH-1:0] right_val;
  logic signed [TERM_WIDTH-1:0] left_val;
  logic signed [TERM_WIDTH-1:0] fit_chk;
  logic [EXP_WIDTH-1:0]         right_amt;
  logic [SH_WIDTH-1:0]          left_amt;
  logic [SH_WIDTH-1:0]          fit_amt;
  logic                         big_left;
  logic                         fits;
  logic                         is_neg;

  assign ext    = TERM_WIDTH'(acc_value);
  assign is_neg = acc_value[ACC_WIDTH-1];

  // Right shift: amounts past the width fill with the sign, as required.
  assign right_amt = $unsigned(-exponent);
  assign right_val = ext >>> right_amt;

  // Left shift: the value fits when everything above the kept bits is sign.
  assign big_left = (exponent >= EXP_WIDTH'(TERM_WIDTH));
  assign left_amt = exponent[SH_WIDTH-1:0];
  assign left_val = ext <<< left_amt;
  assign fit_amt  = SH_WIDTH'(TERM_WIDTH - 1) - left_amt;
  assign fit_chk  = ext >>> fit_amt;
  assign fits     = (&fit_chk) || (~|fit_chk);

  // Select the shift direction and apply the term-range clamp.
  always_comb begin
    term = left_val;
    clip = 1'b0;
    if (exponent[EXP_WIDTH-1]) begin
      term = right_val;
    end else if (big_left) begin
      clip = |acc_value;
      if (!(|acc_value)) begin
        term = '0;
      end else begin
        term = is_neg ? TERM_MIN : TERM_MAX;
      end
    end else if (!fits) begin
      clip = 1'b1;
      term = is_neg ? TERM_MIN : TERM_MAX;
    end
  end

endmodule

// File: rtl/core/ternary_multiterm_row_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_multiterm_row_dot: ternary-weight row dot product, top level
// Accumulates activations per weight term and emits one saturated, scaled
// row sum on each item marked last.
// ----------------------------------------------------------------------------
// The block takes one input item per clock cycle, sustained, as long as the
// result side keeps taking results. Each item is first captured in an input
// register; on its transfer out of that register the per-term accumulators
// add or subtract the activation in a single adder stage per term. Items
// marked last then travel three more stages (term scaling, pairwise sums,
// final sum with saturation), the last of them the result register. Stall
// on the result side propagates back through stages that hold a row
// result; items that are not last drain from the input register
// regardless. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module ternary_multiterm_row_dot
  import tmrd_pkg::*;
#(
  parameter int TERMS     = TERMS_DEF,
  parameter int ACT_WIDTH = ACT_WIDTH_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tmrd_in_if.sink    in_ch,
  tmrd_out_if.source out_ch,
  tmrd_cfg_if.sink   cfg_ch
);

  localparam int PAIRS      = (TERMS + 1) / 2;
  localparam int PAIR_WIDTH = TERM_WIDTH + 1;
  localparam int SUM_WIDTH  = TERM_WIDTH + 3;
  localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

  // Configuration registers.
  logic [COUNT_WIDTH-1:0]    active_terms_r;
  logic [CFG_DATA_WIDTH-1:0] exponents_r;

  // Input register stage.
  logic                        s0_v_r;
  logic signed [ACT_WIDTH-1:0] act_r;
  logic [MASK_WIDTH-1:0]       nz_r;
  logic [MASK_WIDTH-1:0]       neg_r;
  logic                        last_r;

  // Accumulators and row snapshot.
  logic signed [ACC_WIDTH-1:0] acc_r   [TERMS];
  logic signed [ACC_WIDTH-1:0] acc_nxt [TERMS];
  logic signed [ACC_WIDTH-1:0] snap_r  [TERMS];
  logic                        s1_v_r;

  // Scaled terms.
  logic signed [TERM_WIDTH-1:0] term_nxt [TERMS];
  logic signed [TERM_WIDTH-1:0] term_r   [TERMS];
  logic [TERMS-1:0]             tclip_nxt;
  logic [TERMS-1:0]             tclip_r;
  logic                         s2_v_r;

  // Pairwise sums.
  logic signed [PAIR_WIDTH-1:0] pair_nxt [PAIRS];
  logic signed [PAIR_WIDTH-1:0] pair_r   [PAIRS];
  logic                         s3_clip_r;
  logic                         s3_v_r;

  // Final sum and result register.
  logic signed [SUM_WIDTH-1:0]  total;
  logic signed [OUT_WIDTH-1:0]  row_sum_nxt;
  logic                         sat_nxt;
  logic                         out_v_r;
  logic signed [OUT_WIDTH-1:0]  row_sum_r;
  logic                         sat_r;

  // Stage handshakes.
  logic s0_go;
  logic s1_rdy;
  logic s2_rdy;
  logic s3_rdy;
  logic out_rdy;
  logic signed [ACC_WIDTH-1:0] act_ext;

  assign out_rdy = !out_v_r || out_ch.ready;
  assign s3_rdy  = !s3_v_r || out_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign s0_go   = s0_v_r && (!last_r || s1_rdy);

  assign in_ch.ready  = !s0_v_r || s0_go;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_v_r;
  assign out_ch.row_sum   = row_sum_r;
  assign out_ch.saturated = sat_r;

  // Register writes; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_terms_r <= ACTIVE_TERMS_RESET;
      exponents_r    <= EXPONENTS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ACTIVE_TERMS: active_terms_r <= cfg_ch.data[COUNT_WIDTH-1:0];
        REG_EXPONENTS:    exponents_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r  <= in_ch.activation;
      nz_r   <= in_ch.nonzero_bits;
      neg_r  <= in_ch.negative_bits;
      last_r <= in_ch.row_last;
    end
  end

  // Per-term add, subtract or skip for the item in the input register.
  assign act_ext = ACC_WIDTH'(act_r);

  always_comb begin
    for (int k = 0; k < TERMS; k++) begin
      acc_nxt[k] = acc_r[k];
      if ((COUNT_WIDTH'(k) < active_terms_r) && nz_r[k]) begin
        acc_nxt[k] = neg_r[k] ? (acc_r[k] - act_ext) : (acc_r[k] + act_ext);
      end
    end
  end

  // Accumulators update on each transfer out of the input register and
  // clear at the end of a row, when the row's values are snapshotted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TERMS; k++) begin
        acc_r[k] <= '0;
      end
    end else if (s0_go) begin
      for (int k = 0; k < TERMS; k++) begin
        acc_r[k] <= last_r ? '0 : acc_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && last_r) begin
      for (int k = 0; k < TERMS; k++) begin
        snap_r[k] <= (COUNT_WIDTH'(k) < active_terms_r) ? acc_nxt[k] : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= s0_go && last_r;
    end
  end

  // Term scaling units.
  for (genvar k = 0; k < TERMS; k++) begin : g_scale
    tmrd_scale #(
      .ACC_WIDTH (ACC_WIDTH)
    ) u_scale (
      .acc_value (snap_r[k]),
      .exponent  (exponents_r[EXP_WIDTH*k +: EXP_WIDTH]),
      .term      (term_nxt[k]),
      .clip      (tclip_nxt[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      term_r  <= term_nxt;
      tclip_r <= tclip_nxt;
    end
  end

  // Pairwise sums of the scaled terms.
  for (genvar p = 0; p < PAIRS; p++) begin : g_pair
    if (2 * p + 1 < TERMS) begin : g_two
      assign pair_nxt[p] = PAIR_WIDTH'(term_r[2*p]) + PAIR_WIDTH'(term_r[2*p+1]);
    end else begin : g_one
      assign pair_nxt[p] = PAIR_WIDTH'(term_r[2*p]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_rdy) begin
      pair_r    <= pair_nxt;
      s3_clip_r <= |tclip_r;
    end
  end

  // Final sum and clamp to the result range.
  always_comb begin
    total = '0;
    for (int p = 0; p < PAIRS; p++) begin
      total = total + SUM_WIDTH'(pair_r[p]);
    end
  end

  always_comb begin
    row_sum_nxt = total[OUT_WIDTH-1:0];
    sat_nxt     = s3_clip_r;
    if (!((&total[SUM_WIDTH-1:OUT_WIDTH-1]) || (~|total[SUM_WIDTH-1:OUT_WIDTH-1]))) begin
      row_sum_nxt = total[SUM_WIDTH-1] ? OUT_MIN : OUT_MAX;
      sat_nxt     = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && out_rdy) begin
      row_sum_r <= row_sum_nxt;
      sat_r     <= sat_nxt;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ternary multi-term row dot block
// Streams rows of activations with ternary weight bits through the block
// under several term counts and exponent settings. It tracks the per-term
// accumulators itself, works out the scaled and saturated row sum of every
// row, and compares each result transfer with the oldest pending row.
// ----------------------------------------------------------------------------
module testbench;
  import tmrd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 60;
  localparam int IDLE_PCT       = 14;

  // Wide enough for any shifted accumulator and any sum of eight terms.
  typedef logic signed [127:0] wide_t;

  localparam wide_t TERM_MAX = (wide_t'(1) <<< (TERM_WIDTH - 1)) - 1;
  localparam wide_t TERM_MIN = -(wide_t'(1) <<< (TERM_WIDTH - 1));
  localparam wide_t ROW_MAX  = (wide_t'(1) <<< (OUT_WIDTH - 1)) - 1;
  localparam wide_t ROW_MIN  = -(wide_t'(1) <<< (OUT_WIDTH - 1));

  typedef struct {
    logic signed [OUT_WIDTH-1:0] row_sum;
    logic                        saturated;
  } row_result_t;

  // Tracks term accumulators and registers, and holds the row sums still due.
  class row_sum_tracker;
    logic [COUNT_WIDTH-1:0]          term_count;
    logic [CFG_DATA_WIDTH-1:0]       exponents;
    logic signed [ACC_WIDTH_DEF-1:0] term_acc[TERMS_DEF];
    row_result_t                     expected_rows[$];
    int                              errors;

    function new();
      term_count = ACTIVE_TERMS_RESET;
      exponents  = EXPONENTS_RESET;
      foreach (term_acc[k]) term_acc[k] = '0;
      errors = 0;
    endfunction

    // A write to any index other than the two registers changes nothing.
    function void write_reg(logic [CFG_IDX_WIDTH-1:0] index,
                            logic [CFG_DATA_WIDTH-1:0] data);
      if (index == REG_ACTIVE_TERMS) begin
        term_count = data[COUNT_WIDTH-1:0];
      end else if (index == REG_EXPONENTS) begin
        exponents = data;
      end
    endfunction

    // Scales one accumulator by a power of two and clips it to the term range.
    function wide_t scale_term(logic signed [ACC_WIDTH_DEF-1:0] acc, int e,
                               output bit clipped);
      wide_t v;
      wide_t shifted;
      v       = acc;
      clipped = 1'b0;
      if (v == 0) return 0;
      // Right shifts floor; a shift past the accumulator width leaves the sign.
      if (e < 0) return v >>> ((-e > 127) ? 127 : -e);
      if (e >= TERM_WIDTH) begin
        clipped = 1'b1;
        return (v > 0) ? TERM_MAX : TERM_MIN;
      end
      shifted = v <<< e;
      if (shifted > TERM_MAX) begin
        clipped = 1'b1;
        return TERM_MAX;
      end
      if (shifted < TERM_MIN) begin
        clipped = 1'b1;
        return TERM_MIN;
      end
      return shifted;
    endfunction

    // Accumulates one accepted item; a row end queues the expected row sum.
    function void note_item(logic signed [ACT_WIDTH_DEF-1:0] activation,
                            logic [MASK_WIDTH-1:0] nonzero,
                            logic [MASK_WIDTH-1:0] negative, logic last);
      int          used;
      wide_t       total;
      bit          clipped;
      bit          any_clip;
      row_result_t row;
      used = (term_count > TERMS_DEF) ? TERMS_DEF : term_count;
      for (int k = 0; k < used; k++) begin
        if (nonzero[k]) begin
          if (negative[k]) term_acc[k] = term_acc[k] - activation;
          else term_acc[k] = term_acc[k] + activation;
        end
      end
      if (!last) return;
      total    = 0;
      any_clip = 1'b0;
      for (int k = 0; k < used; k++) begin
        total += scale_term(term_acc[k],
                            int'($signed(exponents[EXP_WIDTH*k +: EXP_WIDTH])),
                            clipped);
        any_clip |= clipped;
      end
      if (total > ROW_MAX) begin
        total    = ROW_MAX;
        any_clip = 1'b1;
      end else if (total < ROW_MIN) begin
        total    = ROW_MIN;
        any_clip = 1'b1;
      end
      foreach (term_acc[k]) term_acc[k] = '0;
      row.row_sum   = total[OUT_WIDTH-1:0];
      row.saturated = any_clip;
      expected_rows.push_back(row);
    endfunction

    // Compares one result transfer with the oldest pending row.
    function void check_row(logic signed [OUT_WIDTH-1:0] row_sum, logic saturated);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        $error("Row result with no row pending: row_sum %0d, saturated %0b",
               row_sum, saturated);
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      if (row_sum !== want.row_sum) begin
        $error("row_sum: expected %0d, actual %0d", want.row_sum, row_sum);
        errors++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  bit             clk;
  logic           rst_n;
  bit             calm;
  int             idle_cycles;
  row_sum_tracker tracker;

  tmrd_in_if #(.ACT_WIDTH(ACT_WIDTH_DEF)) in_ch ();
  tmrd_out_if                             out_ch ();
  tmrd_cfg_if                             cfg_ch ();

  ternary_multiterm_row_dot #(
    .TERMS    (TERMS_DEF),
    .ACT_WIDTH(ACT_WIDTH_DEF),
    .ACC_WIDTH(ACC_WIDTH_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The result side stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Sample every transfer at the rising edge, and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tracker.note_item(in_ch.activation, in_ch.nonzero_bits, in_ch.negative_bits,
                          in_ch.row_last);
      end
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_row(out_ch.row_sum, out_ch.saturated);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.write_reg(cfg_ch.index, cfg_ch.data);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Presents one item, with an occasional one-cycle gap first, and waits for
  // its transfer. Valid stays high afterwards so back-to-back items need no
  // extra step.
  task automatic send_item(logic signed [ACT_WIDTH_DEF-1:0] activation,
                           logic [MASK_WIDTH-1:0] nonzero,
                           logic [MASK_WIDTH-1:0] negative, logic last);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.activation    <= activation;
    in_ch.nonzero_bits  <= nonzero;
    in_ch.negative_bits <= negative;
    in_ch.row_last      <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds one register write until its transfer; the caller lowers valid.
  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] index,
                           logic [CFG_DATA_WIDTH-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Lets every pending row come out, then leaves time for trailing items.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Rewrites both registers while idle, optionally poking an unused index too.
  task automatic set_config(logic [COUNT_WIDTH-1:0] count,
                            logic [CFG_DATA_WIDTH-1:0] exps, bit poke_unused);
    wait_idle();
    write_reg(REG_ACTIVE_TERMS, CFG_DATA_WIDTH'(count));
    write_reg(REG_EXPONENTS, exps);
    if (poke_unused) begin
      write_reg(CFG_IDX_WIDTH'($urandom_range(15, REG_EXPONENTS + 1)),
                {$urandom, $urandom});
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic signed [ACT_WIDTH_DEF-1:0] act;
    logic [MASK_WIDTH-1:0]           nz;
    logic [CFG_DATA_WIDTH-1:0]       exps;
    logic [COUNT_WIDTH-1:0]          count;
    int                              sent;
    int                              len;
    byte                             boundary_exps[12];

    boundary_exps = '{59, 60, 58, -62, -63, -64, 33, -40, 127, -128, 1, -1};
    rst_n                = 1'b0;
    calm                 = 1'b0;
    idle_cycles          = 0;
    in_ch.valid          = 1'b0;
    in_ch.activation     = '0;
    in_ch.nonzero_bits   = '0;
    in_ch.negative_bits  = '0;
    in_ch.row_last       = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    tracker              = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: four terms, no scaling. Field extremes and weight cases.
    send_item(16'sh7FFF, 8'hFF, 8'h00, 1'b0);
    send_item(16'sh8000, 8'hFF, 8'h00, 1'b1);
    send_item(16'sh8000, 8'h0F, 8'h0F, 1'b1);
    send_item(16'sh0000, 8'hFF, 8'hFF, 1'b1);
    // A sign bit without its nonzero bit means a zero weight.
    send_item(16'sh3039, 8'h00, 8'hFF, 1'b1);
    // Bits of inactive terms are ignored.
    send_item(-16'sd1, 8'hF0, 8'h00, 1'b1);
    send_item(16'sh7FFF, 8'h05, 8'h01, 1'b0);
    send_item(16'sh0064, 8'h0A, 8'h08, 1'b1);

    // All terms, one exponent per special case: clip at 59 and beyond,
    // floor shifts, shifts past the width, and the largest exponents.
    set_config(4'd8, 64'h01_21_7F_80_C1_FF_3C_3B, 1'b1);
    send_item(16'sh7FFF, 8'hFF, 8'h00, 1'b1);
    send_item(16'sh8000, 8'hFF, 8'hFF, 1'b1);
    send_item(16'sh8000, 8'hFF, 8'h00, 1'b1);
    send_item(16'sh0001, 8'h04, 8'h00, 1'b1);
    send_item(-16'sd1, 8'h0C, 8'h00, 1'b1);
    send_item(16'sh0000, 8'hFF, 8'h00, 1'b1);

    // Terms that fit but whose sum overflows the result width.
    set_config(4'd2, 64'h21_21_21_21_21_21_21_21, 1'b0);
    send_item(16'sh7FFF, 8'h03, 8'h00, 1'b1);
    send_item(16'sh8000, 8'h03, 8'h00, 1'b1);
    send_item(16'sh7FFF, 8'h03, 8'h02, 1'b1);

    // No terms in use, then a count above the number of terms.
    set_config(4'd0, 64'h05_05_05_05_05_05_05_05, 1'b0);
    send_item(16'sh7FFF, 8'hFF, 8'h00, 1'b1);
    set_config(4'd15, 64'h00_00_00_00_00_00_00_00, 1'b0);
    send_item(16'sh1234, 8'hFF, 8'hAA, 1'b0);
    send_item(16'sh8000, 8'hFF, 8'h55, 1'b1);

    // Random rows under a series of settings.
    for (int p = 0; p < 8; p++) begin
      count = '0;
      exps  = '0;
      case (p)
        0: count = 4'd8;
        1: begin
          count = 4'd15;
          exps  = 64'h7F_7F_7F_7F_7F_7F_7F_7F;
        end
        2: begin
          count = 4'd1;
          exps  = 64'h80_80_80_80_80_80_80_80;
        end
        3: exps = {$urandom, $urandom};
        4: begin
          count = 4'd8;
          for (int k = 0; k < TERMS_DEF; k++) exps[8*k +: 8] = 8'($urandom_range(60) - 20);
        end
        5: begin
          count = 4'($urandom_range(15, 1));
          exps  = {$urandom, $urandom};
        end
        6: begin
          count = 4'd8;
          for (int k = 0; k < TERMS_DEF; k++) exps[8*k +: 8] = 8'($urandom_range(8));
        end
        default: begin
          count = 4'($urandom_range(15));
          for (int k = 0; k < TERMS_DEF; k++) begin
            exps[8*k +: 8] = boundary_exps[$urandom_range(11)];
          end
        end
      endcase
      set_config(count, exps, p[0]);
      // One phase runs with neither side idling.
      calm = (p == 6);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(11))
            0: act = 16'sh8000;
            1: act = 16'sh7FFF;
            2: act = '0;
            3: act = -16'sd1;
            default: act = 16'($urandom);
          endcase
          nz = ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom);
          send_item(act, nz, 8'($urandom), i == len - 1);
          sent++;
        end
      end
      calm = 1'b0;
    end

    // Drain the remaining rows, then give the block time to show anything extra.
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
